// ===== design/wpb_pkg.sv =====
package wpb_pkg;

  // Field widths of the frame and result words.
  localparam int SMP_W  = 16;
  localparam int FRM_W  = 16;
  localparam int IDX_W  = 24;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Groups at or beyond this index are counted but never stored or reported.
  localparam logic [IDX_W-1:0] SUMMARY_COUNT = 24'd1024;

  // Kinds of result word.
  localparam logic KIND_BUCKET = 1'b0;
  localparam logic KIND_GROUP  = 1'b1;

  typedef logic signed [SMP_W-1:0] smp_t;

  // Register map, one 32-bit register every four bytes.
  typedef enum logic [1:0] {
    REG_SPB    = 2'd0,
    REG_TOTAL  = 2'd1,
    REG_BPG    = 2'd2,
    REG_STEREO = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [FRM_W-1:0] spb;
    logic [IDX_W-1:0] total;
    logic [IDX_W-1:0] bpg;
    logic             stereo;
  } cfg_t;

  typedef struct packed {
    smp_t min0;
    smp_t max0;
    smp_t min1;
    smp_t max1;
  } ext_t;

  // Empty extremes: minimum above maximum.
  localparam smp_t SMP_MAX = smp_t'({1'b0, {(SMP_W-1){1'b1}}});
  localparam smp_t SMP_MIN = smp_t'({1'b1, {(SMP_W-1){1'b0}}});
  localparam ext_t EXT_EMPTY = '{min0: SMP_MAX, max0: SMP_MIN,
                                 min1: SMP_MAX, max1: SMP_MIN};

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] idx;
    smp_t             min_first;
    smp_t             max_first;
    smp_t             min_second;
    smp_t             max_second;
    logic             run_last;
  } res_t;

  // Up to two result words written into the output queue in one cycle.
  typedef struct packed {
    logic push0;
    logic push1;
    res_t res0;
    res_t res1;
  } push_t;

  // Builds a result word; an empty channel and the second channel in mono read as zero.
  function automatic res_t make_entry(input logic kind, input logic [IDX_W-1:0] idx,
                                      input ext_t e, input logic stereo);
    res_t r;
    r.kind     = kind;
    r.idx      = idx;
    r.run_last = 1'b0;
    if (e.min0 > e.max0) begin
      r.min_first = '0;
      r.max_first = '0;
    end else begin
      r.min_first = e.min0;
      r.max_first = e.max0;
    end
    if (!stereo || (e.min1 > e.max1)) begin
      r.min_second = '0;
      r.max_second = '0;
    end else begin
      r.min_second = e.min1;
      r.max_second = e.max1;
    end
    return r;
  endfunction

endpackage

// ===== design/wpb_in_if.sv =====
interface wpb_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [wpb_pkg::SMP_W-1:0] sample_first;
  logic signed [wpb_pkg::SMP_W-1:0] sample_second;
  logic                         final_frame;

  modport source (output valid, output sample_first, output sample_second,
                  output final_frame, input ready);
  modport sink   (input valid, input sample_first, input sample_second,
                  input final_frame, output ready);
endinterface

// ===== design/wpb_out_if.sv =====
interface wpb_out_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [wpb_pkg::IDX_W-1:0]        entry_index;
  logic signed [wpb_pkg::SMP_W-1:0] min_first;
  logic signed [wpb_pkg::SMP_W-1:0] max_first;
  logic signed [wpb_pkg::SMP_W-1:0] min_second;
  logic signed [wpb_pkg::SMP_W-1:0] max_second;
  logic                             run_last;

  modport source (output valid, output result_kind, output entry_index,
                  output min_first, output max_first, output min_second,
                  output max_second, output run_last, input ready);
  modport sink   (input valid, input result_kind, input entry_index,
                  input min_first, input max_first, input min_second,
                  input max_second, input run_last, output ready);
endinterface

// ===== design/wpb_cfg.sv =====
module wpb_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wpb_pkg::ADDR_W-1:0] paddr,
  input  logic [wpb_pkg::DATA_W-1:0] pwdata,
  output logic [wpb_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output wpb_pkg::cfg_t              cfg_o
);

  wpb_pkg::cfg_t    cfg_q;
  wpb_pkg::reg_idx_e reg_idx;
  logic             wr_en;

  assign reg_idx = wpb_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spb    <= 16'd256;
      cfg_q.total  <= 24'd1;
      cfg_q.bpg    <= 24'd1;
      cfg_q.stereo <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        wpb_pkg::REG_SPB:    cfg_q.spb    <= pwdata[wpb_pkg::FRM_W-1:0];
        wpb_pkg::REG_TOTAL:  cfg_q.total  <= pwdata[wpb_pkg::IDX_W-1:0];
        wpb_pkg::REG_BPG:    cfg_q.bpg    <= pwdata[wpb_pkg::IDX_W-1:0];
        wpb_pkg::REG_STEREO: cfg_q.stereo <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back, zero-extended.
  always_comb begin
    case (reg_idx)
      wpb_pkg::REG_SPB:    prdata = {{(wpb_pkg::DATA_W-wpb_pkg::FRM_W){1'b0}}, cfg_q.spb};
      wpb_pkg::REG_TOTAL:  prdata = {{(wpb_pkg::DATA_W-wpb_pkg::IDX_W){1'b0}}, cfg_q.total};
      wpb_pkg::REG_BPG:    prdata = {{(wpb_pkg::DATA_W-wpb_pkg::IDX_W){1'b0}}, cfg_q.bpg};
      wpb_pkg::REG_STEREO: prdata = {{(wpb_pkg::DATA_W-1){1'b0}}, cfg_q.stereo};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== design/wpb_fold.sv =====
module wpb_fold (
  input  logic           clk_i,
  input  logic           rst_ni,
  wpb_in_if.sink         frame_i,
  input  wpb_pkg::cfg_t  cfg_i,
  input  logic           space_i,
  output wpb_pkg::push_t push_o
);

  // Input register.
  logic                 in_vld_q;
  wpb_pkg::smp_t        s0_q, s1_q;
  logic                 final_q;
  logic                 fire;

  // Running state.
  logic [wpb_pkg::FRM_W-1:0] frame_q, frame_d;
  logic [wpb_pkg::IDX_W-1:0] bucket_q, bucket_d;
  logic [wpb_pkg::IDX_W-1:0] gfill_q, gfill_d;
  logic [wpb_pkg::IDX_W-1:0] group_q, group_d;
  wpb_pkg::ext_t             be_q, be_d, ge_q, ge_d;
  logic                      bhas_q, bhas_d, ghas_q, ghas_d;

  logic                      active, in_sum, bucket_done, group_done;
  logic [wpb_pkg::FRM_W-1:0] fc;
  logic [wpb_pkg::IDX_W-1:0] gf;
  wpb_pkg::ext_t             be_n, ge_n;
  logic                      bhas_n, ghas_n;
  logic                      c0_v, c1_v, c2_v, c3_v, bv, gv;
  wpb_pkg::res_t             bres, gres;

  assign fire          = in_vld_q & space_i;
  assign frame_i.ready = ~in_vld_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (frame_i.ready) begin
      in_vld_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.ready && frame_i.valid) begin
      s0_q    <= frame_i.sample_first;
      s1_q    <= frame_i.sample_second;
      final_q <= frame_i.final_frame;
    end
  end

  // Fold the registered frame into the bucket and group extremes.
  always_comb begin
    active = bucket_q < cfg_i.total;
    in_sum = group_q < wpb_pkg::SUMMARY_COUNT;

    be_n = be_q;
    if (active) begin
      if (s0_q < be_n.min0) be_n.min0 = s0_q;
      if (s0_q > be_n.max0) be_n.max0 = s0_q;
      if (cfg_i.stereo) begin
        if (s1_q < be_n.min1) be_n.min1 = s1_q;
        if (s1_q > be_n.max1) be_n.max1 = s1_q;
      end
    end
    bhas_n = bhas_q | active;

    fc          = frame_q + 1'b1;
    bucket_done = active && (fc == cfg_i.spb);

    ge_n   = ge_q;
    ghas_n = ghas_q;
    if (bucket_done && in_sum) begin
      if (be_n.min0 < ge_n.min0) ge_n.min0 = be_n.min0;
      if (be_n.max0 > ge_n.max0) ge_n.max0 = be_n.max0;
      if (be_n.min1 < ge_n.min1) ge_n.min1 = be_n.min1;
      if (be_n.max1 > ge_n.max1) ge_n.max1 = be_n.max1;
      ghas_n = 1'b1;
    end
    gf         = gfill_q + 1'b1;
    group_done = bucket_done && (gf == cfg_i.bpg);

    // Next state after the completed bucket and group.
    frame_d  = active ? fc : frame_q;
    bucket_d = bucket_q;
    be_d     = be_n;
    bhas_d   = bhas_n;
    gfill_d  = gfill_q;
    group_d  = group_q;
    ge_d     = ge_n;
    ghas_d   = ghas_n;
    if (bucket_done) begin
      frame_d  = '0;
      bucket_d = bucket_q + 1'b1;
      be_d     = wpb_pkg::EXT_EMPTY;
      bhas_d   = 1'b0;
      gfill_d  = gf;
      if (group_done) begin
        gfill_d = '0;
        group_d = group_q + 1'b1;
        ge_d    = wpb_pkg::EXT_EMPTY;
        ghas_d  = 1'b0;
      end
    end

    // Completed entries, then the flush of partial ones on the final frame.
    c0_v = bucket_done;
    c1_v = group_done && in_sum;
    c2_v = final_q && bhas_d && (bucket_d < cfg_i.total);
    c3_v = final_q && ghas_d && (group_d < wpb_pkg::SUMMARY_COUNT);

    bv   = c0_v | c2_v;
    gv   = c1_v | c3_v;
    bres = c0_v ? wpb_pkg::make_entry(wpb_pkg::KIND_BUCKET, bucket_q, be_n, cfg_i.stereo)
                : wpb_pkg::make_entry(wpb_pkg::KIND_BUCKET, bucket_d, be_d, cfg_i.stereo);
    gres = c1_v ? wpb_pkg::make_entry(wpb_pkg::KIND_GROUP, group_q, ge_n, cfg_i.stereo)
                : wpb_pkg::make_entry(wpb_pkg::KIND_GROUP, group_d, ge_d, cfg_i.stereo);
    bres.run_last = ~gv;
    gres.run_last = 1'b1;

    // A bucket entry always precedes a group entry.
    if (bv) begin
      push_o.push0 = fire;
      push_o.push1 = fire & gv;
      push_o.res0  = bres;
      push_o.res1  = gres;
    end else begin
      push_o.push0 = fire & gv;
      push_o.push1 = 1'b0;
      push_o.res0  = gres;
      push_o.res1  = bres;
    end

    // The final frame returns everything to its start values.
    if (final_q) begin
      frame_d  = '0;
      bucket_d = '0;
      gfill_d  = '0;
      group_d  = '0;
      be_d     = wpb_pkg::EXT_EMPTY;
      ge_d     = wpb_pkg::EXT_EMPTY;
      bhas_d   = 1'b0;
      ghas_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      bucket_q <= '0;
      gfill_q  <= '0;
      group_q  <= '0;
      be_q     <= wpb_pkg::EXT_EMPTY;
      ge_q     <= wpb_pkg::EXT_EMPTY;
      bhas_q   <= 1'b0;
      ghas_q   <= 1'b0;
    end else if (fire) begin
      frame_q  <= frame_d;
      bucket_q <= bucket_d;
      gfill_q  <= gfill_d;
      group_q  <= group_d;
      be_q     <= be_d;
      ge_q     <= ge_d;
      bhas_q   <= bhas_d;
      ghas_q   <= ghas_d;
    end
  end

endmodule

// ===== design/wpb_outq.sv =====
module wpb_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wpb_pkg::push_t push_i,
  output logic           space_o,
  wpb_out_if.source      result_o
);

  // Four-word queue: up to two words in and one word out per cycle.
  wpb_pkg::res_t mem_q [4];
  logic [1:0]    wr_q, rd_q;
  logic [2:0]    cnt_q;
  logic          pop;
  wpb_pkg::res_t head;

  assign pop     = result_o.valid & result_o.ready;
  assign space_o = cnt_q <= 3'd2;
  assign head    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wr_q + 2'd1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + {1'b0, push_i.push0} + {1'b0, push_i.push1};
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {2'b0, push_i.push0} + {2'b0, push_i.push1} - {2'b0, pop};
    end
  end

  // Head word on the result channel.
  assign result_o.valid       = cnt_q != 3'd0;
  assign result_o.result_kind = head.kind;
  assign result_o.entry_index = head.idx;
  assign result_o.min_first   = head.min_first;
  assign result_o.max_first   = head.max_first;
  assign result_o.min_second  = head.min_second;
  assign result_o.max_second  = head.max_second;
  assign result_o.run_last    = head.run_last;

endmodule

// ===== design/waveform_peak_bucketer_core.sv =====
// A frame word is registered at acceptance, and its results are written into the output
// queue once the queue holds at most two words; the queue's head word is offered on the
// result channel. Throughput: one frame word per cycle when it gives at most one result
// and the result channel is not stalled; the single output port passes one word at a
// time, so the two results of a frame leave the four-word queue one after the other.
// Reset (rst_ni, asynchronous, active low) clears the counters, extremes and queue and loads
// the registers with 256 frames per bucket, one bucket in total, one bucket per group, stereo.
module waveform_peak_bucketer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wpb_in_if.sink                     frame_i,
  wpb_out_if.source                  result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wpb_pkg::ADDR_W-1:0] paddr,
  input  logic [wpb_pkg::DATA_W-1:0] pwdata,
  output logic [wpb_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  wpb_pkg::cfg_t  cfg;
  wpb_pkg::push_t push;
  logic           space;

  // Configuration registers.
  wpb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Frame register and min/max folding.
  wpb_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_i),
    .cfg_i   (cfg),
    .space_i (space),
    .push_o  (push)
  );

  // Result queue.
  wpb_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .space_o  (space),
    .result_o (result_o)
  );

endmodule
